### design/int8_fc_layer_requant_core_defines.svh
// assertion macros for the fully connected layer core
`ifndef INT8_FC_LAYER_REQUANT_CORE_DEFINES_SVH
`define INT8_FC_LAYER_REQUANT_CORE_DEFINES_SVH

// property checked on every rising edge outside reset
`define FCRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// value unchanged in the cycle after the condition
`define FCRQ_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

### design/fcrq_pkg.sv
// shared types, codes and constants of the fully connected layer core
package fcrq_pkg;

    localparam int MAX_INPUTS_DEF  = 256;
    localparam int MAX_OUTPUTS_DEF = 64;
    localparam int FIFO_DEPTH      = 4;

    localparam int KIND_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;
    localparam int DATA_W     = 32;
    localparam int VLEN_W     = 9;
    localparam int RCNT_W     = 7;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int ELEM_W     = 8;
    localparam int PROD_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_OUTPUT = 3'd4;

    localparam logic signed [DATA_W-1:0] SAT_HI = 32'sd127;
    localparam logic signed [DATA_W-1:0] SAT_LO = -32'sd128;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACT     = 2'd0,
        KIND_WEIGHT  = 2'd1,
        KIND_BIAS    = 2'd2,
        KIND_COMPUTE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [VLEN_W-1:0]  vector_length;
        logic [RCNT_W-1:0]  row_count;
        logic [SHIFT_W-1:0] shift_amount;
        logic               relu_enable;
        logic               narrow_output;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic              drop;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

### design/int8_fc_layer_requant_core.sv
// top level of the int8 fully connected layer with requantisation
//
// channel | handshake            | word
// in      | in_valid / in_ready  | kind, row_index, column_index, data_value
// out     | out_valid / out_ready| result_value, result_row, last_flag
// cfg     | cfg_we               | cfg_index, cfg_data
//
// load words retire in the back end at one a cycle while the sequencer is idle, behind a four-entry queue
// a compute word runs its rows one after another through the
// one multiply-accumulate unit and the single read port of each store
// a stalled result register holds the sequencer, the queue keeps taking words until it is full
// stores are not cleared by reset, configuration resets to its default values
module int8_fc_layer_requant_core #(
    parameter int MAX_INPUTS  = fcrq_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = fcrq_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fcrq_pkg::KIND_W-1:0]        kind,
    input  logic [fcrq_pkg::ROW_W-1:0]         row_index,
    input  logic [fcrq_pkg::COL_W-1:0]         column_index,
    input  logic signed [fcrq_pkg::DATA_W-1:0] data_value,
    input  logic                               cfg_we,
    input  logic [fcrq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcrq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [fcrq_pkg::DATA_W-1:0] result_value,
    output logic [fcrq_pkg::ROW_W-1:0]         result_row,
    output logic                               last_flag
);

    import fcrq_pkg::*;

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    fcrq_front #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .row_index    (row_index),
        .column_index (column_index),
        .data_value   (data_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .full         (full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    fcrq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    fcrq_back #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_row   (result_row),
        .last_flag    (last_flag)
    );

endmodule

### design/fcrq_ram.sv
// generic single write, single read memory with registered read data
module fcrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/fcrq_fifo.sv
// short command queue between the front and back ends
module fcrq_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fcrq_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output fcrq_pkg::cmd_t head
);

    import fcrq_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);

    cmd_t          slot_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

endmodule

### design/fcrq_front.sv
// input acceptance, command classification and configuration registers
module fcrq_front #(
    parameter int MAX_INPUTS  = fcrq_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = fcrq_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [fcrq_pkg::KIND_W-1:0]        kind,
    input  logic [fcrq_pkg::ROW_W-1:0]         row_index,
    input  logic [fcrq_pkg::COL_W-1:0]         column_index,
    input  logic signed [fcrq_pkg::DATA_W-1:0] data_value,
    input  logic                               cfg_we,
    input  logic [fcrq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fcrq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fcrq_pkg::cfg_t                     cfg,
    input  logic                               full,
    output logic                               push,
    output fcrq_pkg::cmd_t                     push_cmd
);

    import fcrq_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    kind_t kind_in;
    logic  col_oob;
    logic  row_oob;
    logic  drop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VECTOR_LENGTH: cfg_next.vector_length = cfg_data[VLEN_W-1:0];
                CFG_ROW_COUNT:     cfg_next.row_count     = cfg_data[RCNT_W-1:0];
                CFG_SHIFT_AMOUNT:  cfg_next.shift_amount  = cfg_data[SHIFT_W-1:0];
                CFG_RELU_ENABLE:   cfg_next.relu_enable   = cfg_data[0];
                CFG_NARROW_OUTPUT: cfg_next.narrow_output = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vector_length <= VLEN_W'(1);
            cfg_reg.row_count     <= RCNT_W'(1);
            cfg_reg.shift_amount  <= '0;
            cfg_reg.relu_enable   <= 1'b0;
            cfg_reg.narrow_output <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign kind_in = kind_t'(kind);
    assign col_oob = (32'(column_index) >= 32'(MAX_INPUTS));
    assign row_oob = (32'(row_index) >= 32'(MAX_OUTPUTS));

    // loads that fall outside the stores are dropped
    always_comb
    begin
        unique case (kind_in)
            KIND_ACT:     drop = col_oob;
            KIND_WEIGHT:  drop = col_oob || row_oob;
            KIND_BIAS:    drop = row_oob;
            KIND_COMPUTE: drop = 1'b0;
            default:      drop = 1'b0;
        endcase
    end

    assign in_ready      = !full;
    assign push          = in_valid && !full;
    assign push_cmd.kind = kind_in;
    assign push_cmd.drop = drop;
    assign push_cmd.row  = row_index;
    assign push_cmd.col  = column_index;
    assign push_cmd.data = data_value;
    assign cfg           = cfg_reg;

endmodule

### design/fcrq_back.sv
// store writes, multiply-accumulate sequencer, requantisation and result register
module fcrq_back #(
    parameter int MAX_INPUTS  = fcrq_pkg::MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = fcrq_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fcrq_pkg::cfg_t                     cfg,
    input  logic                               empty,
    input  fcrq_pkg::cmd_t                     head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [fcrq_pkg::DATA_W-1:0] result_value,
    output logic [fcrq_pkg::ROW_W-1:0]         result_row,
    output logic                               last_flag
);

    import fcrq_pkg::*;

    localparam int AAW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int BAW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int LW     = $clog2(MAX_INPUTS + 1);
    localparam int RW     = $clog2(MAX_OUTPUTS + 1);
    localparam logic [WAW-1:0] ROW_STRIDE = WAW'(MAX_INPUTS);
    localparam logic [LW-1:0]  LEN_MAX    = LW'(MAX_INPUTS);
    localparam logic [RW-1:0]  ROWS_MAX   = RW'(MAX_OUTPUTS);

    state_t state_reg, state_next;

    logic [LW-1:0]  len_reg;
    logic [RW-1:0]  rows_reg;
    logic [RW-1:0]  row_reg;
    logic [WAW-1:0] row_base_reg;
    logic [LW-1:0]  col_cnt_reg;
    logic           bias_vld_reg;
    logic           rd_vld_reg;
    logic           prod_vld_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0]        acc_reg;
    logic signed [DATA_W-1:0] rq_reg;

    logic                     out_vld_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic                     out_last_reg;

    logic [LW-1:0] len_sat;
    logic [RW-1:0] rows_sat;
    logic          start;
    logic          last_row;
    logic          act_we, wt_we, bias_we;
    logic          issue, bias_rd, out_load;

    logic [ELEM_W-1:0] act_q, wt_q;
    logic [DATA_W-1:0] bias_q;
    logic [WAW-1:0]    wt_waddr, wt_raddr;

    logic signed [DATA_W:0]   sum33;
    logic [DATA_W:0]          rnd33;
    logic signed [DATA_W:0]   shifted33;
    logic signed [DATA_W-1:0] rq_value;
    logic signed [DATA_W-1:0] relu_value;
    logic signed [DATA_W-1:0] final_value;

    assign len_sat  = (32'(cfg.vector_length) > 32'(MAX_INPUTS)) ? LEN_MAX
                                                                : LW'(cfg.vector_length);
    assign rows_sat = (32'(cfg.row_count) > 32'(MAX_OUTPUTS)) ? ROWS_MAX
                                                             : RW'(cfg.row_count);
    assign start    = !empty && (head.kind == KIND_COMPUTE);
    assign last_row = ((row_reg + RW'(1)) == rows_reg);

    // outputs of the sequencer
    always_comb
    begin
        pop      = 1'b0;
        act_we   = 1'b0;
        wt_we    = 1'b0;
        bias_we  = 1'b0;
        issue    = 1'b0;
        bias_rd  = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop = !empty;
                if (!empty && !head.drop)
                begin
                    case (head.kind)
                        KIND_ACT:    act_we  = 1'b1;
                        KIND_WEIGHT: wt_we   = 1'b1;
                        KIND_BIAS:   bias_we = 1'b1;
                        default:     act_we  = 1'b0;
                    endcase
                end
            end
            ST_BIAS:  bias_rd  = 1'b1;
            ST_MAC:   issue    = 1'b1;
            ST_EMIT:  out_load = !out_vld_reg || out_ready;
            default:  pop      = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (rows_sat != '0))
                begin
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:
            begin
                state_next = (len_reg == '0) ? ST_DRAIN : ST_MAC;
            end
            ST_MAC:
            begin
                if ((col_cnt_reg + LW'(1)) == len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!bias_vld_reg && !rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = last_row ? ST_IDLE : ST_BIAS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            rows_reg     <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            col_cnt_reg  <= '0;
            bias_vld_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bias_vld_reg <= bias_rd;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if ((state_reg == ST_IDLE) && start)
            begin
                len_reg      <= len_sat;
                rows_reg     <= rows_sat;
                row_reg      <= '0;
                row_base_reg <= '0;
            end
            if (bias_rd)
            begin
                col_cnt_reg <= '0;
            end
            else if (issue)
            begin
                col_cnt_reg <= col_cnt_reg + LW'(1);
            end
            if (out_load && !last_row)
            begin
                row_reg      <= row_reg + RW'(1);
                row_base_reg <= row_base_reg + ROW_STRIDE;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // rounding add and arithmetic shift, exact in 33 bits
    always_comb
    begin
        rnd33     = (DATA_W + 1)'(1) << (cfg.shift_amount - SHIFT_W'(1));
        sum33     = $signed({acc_reg[DATA_W-1], acc_reg}) + $signed(rnd33);
        shifted33 = sum33 >>> cfg.shift_amount;
        if (cfg.shift_amount == '0)
        begin
            rq_value = $signed(acc_reg);
        end
        else
        begin
            rq_value = shifted33[DATA_W-1:0];
        end
    end

    always_comb
    begin
        relu_value = (cfg.relu_enable && rq_reg[DATA_W-1]) ? '0 : rq_reg;
        final_value = relu_value;
        if (cfg.narrow_output)
        begin
            if (relu_value > SAT_HI)
            begin
                final_value = SAT_HI;
            end
            else if (relu_value < SAT_LO)
            begin
                final_value = SAT_LO;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(act_q) * $signed(wt_q);
        if (bias_vld_reg)
        begin
            acc_reg <= bias_q;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(DATA_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (state_reg == ST_SHIFT)
        begin
            rq_reg <= rq_value;
        end
        if (out_load)
        begin
            out_value_reg <= final_value;
            out_row_reg   <= ROW_W'(row_reg);
            out_last_reg  <= last_row;
        end
    end

    assign wt_waddr = WAW'(head.row) * ROW_STRIDE + WAW'(head.col);
    assign wt_raddr = row_base_reg + WAW'(col_cnt_reg[AAW-1:0]);

    fcrq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_INPUTS)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (AAW'(head.col)),
        .wdata (head.data[ELEM_W-1:0]),
        .re    (issue),
        .raddr (col_cnt_reg[AAW-1:0]),
        .rdata (act_q)
    );

    fcrq_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (WDEPTH)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (head.data[ELEM_W-1:0]),
        .re    (issue),
        .raddr (wt_raddr),
        .rdata (wt_q)
    );

    fcrq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_OUTPUTS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (BAW'(head.row)),
        .wdata (head.data),
        .re    (bias_rd),
        .raddr (row_reg[BAW-1:0]),
        .rdata (bias_q)
    );

    assign out_valid    = out_vld_reg;
    assign result_value = out_value_reg;
    assign result_row   = out_row_reg;
    assign last_flag    = out_last_reg;

endmodule

### design/fcrq_checker.sv
// port-level checks of the fully connected layer core and their binding
`include "int8_fc_layer_requant_core_defines.svh"

module fcrq_checker #(
    parameter int MAX_OUTPUTS = fcrq_pkg::MAX_OUTPUTS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_we,
    input logic [fcrq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [fcrq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [fcrq_pkg::DATA_W-1:0] result_value,
    input logic [fcrq_pkg::ROW_W-1:0]         result_row,
    input logic                               last_flag
);

    import fcrq_pkg::*;

    localparam int RW = $clog2(MAX_OUTPUTS + 1);
    localparam logic [RW-1:0] ROWS_MAX = RW'(MAX_OUTPUTS);

    logic [RW-1:0] rows_reg, rows_next;
    logic          relu_reg, relu_next;
    logic          narrow_reg, narrow_next;

    // shadow of the row count, relu and narrow settings seen on the write port
    always_comb
    begin
        rows_next   = rows_reg;
        relu_next   = relu_reg;
        narrow_next = narrow_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:
                begin
                    rows_next = (32'(cfg_data[RCNT_W-1:0]) > 32'(MAX_OUTPUTS)) ? ROWS_MAX
                                : RW'(cfg_data[RCNT_W-1:0]);
                end
                CFG_RELU_ENABLE:   relu_next   = cfg_data[0];
                CFG_NARROW_OUTPUT: narrow_next = cfg_data[0];
                default:           rows_next   = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= RW'(1);
            relu_reg   <= 1'b0;
            narrow_reg <= 1'b0;
        end
        else
        begin
            rows_reg   <= rows_next;
            relu_reg   <= relu_next;
            narrow_reg <= narrow_next;
        end
    end

    `FCRQ_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid && !out_ready, {out_valid, result_value, result_row, last_flag}, "result word changed while stalled")
    `FCRQ_ASSERT(a_relu_sign, clk, rst_n, out_valid && relu_reg |-> !result_value[DATA_W-1], "negative result with relu on")
    `FCRQ_ASSERT(a_narrow_range, clk, rst_n, out_valid && narrow_reg |-> (result_value <= SAT_HI) && (result_value >= SAT_LO), "narrow result out of int8 range")
    `FCRQ_ASSERT(a_last_row, clk, rst_n, out_valid && last_flag |-> (32'(result_row) + 32'd1) == 32'(rows_reg), "last flag not on final row")

endmodule

bind int8_fc_layer_requant_core fcrq_checker #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
) u_fcrq_checker (.*);

### bench/int8_fc_layer_requant_core_tb.sv
// self-checking testbench for the int8 fully connected layer core with requantisation
`timescale 1ns / 100ps

module int8_fc_layer_requant_core_tb;
    import fcrq_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 500;
    localparam int N_PHASES      = 13;
    localparam int FILL_COLS     = 16;
    localparam int FILL_ROWS     = 8;

    localparam logic [5:0][DATA_W-1:0] DATA_CORNERS = {
        32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_007F, 32'h0000_0080
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ROW_W-1:0]         row;
        logic                     last;
    } neuron_t;

    typedef struct packed {
        logic                     is_reg;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        kind_t                    kind;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic [DATA_W-1:0]        data;
        logic                     typed;
        logic                     has_out;
        logic signed [DATA_W-1:0] out_val;
    } plan_step_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind = '0;
    logic [ROW_W-1:0]         row_index = '0;
    logic [COL_W-1:0]         column_index = '0;
    logic signed [DATA_W-1:0] data_value = '0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic [ROW_W-1:0]         result_row;
    logic                     last_flag;

    logic signed [ELEM_W-1:0] act_mirror [MAX_INPUTS_DEF];
    logic signed [ELEM_W-1:0] wgt_mirror [MAX_OUTPUTS_DEF][MAX_INPUTS_DEF];
    logic signed [DATA_W-1:0] bias_mirror [MAX_OUTPUTS_DEF];
    logic [VLEN_W-1:0]        vec_len = 9'd1;
    logic [RCNT_W-1:0]        row_cnt = 7'd1;
    logic [SHIFT_W-1:0]       shift_amt = '0;
    logic                     relu_on = 1'b0;
    logic                     narrow_on = 1'b0;

    neuron_t pending_neurons [$];
    int      error_count = 0;
    bit      calm = 1'b0;
    bit      squeeze = 1'b0;

    // is_reg, reg, value, kind, row, col, data, typed, has_out, expected
    plan_step_t direct_plan [34] = '{
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'hABCD_EF7F,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_WEIGHT, 6'd0, 8'd0, 32'h1234_567F,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_BIAS, 6'd0, 8'd0, 32'h0000_0000,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd63, 8'd255, 32'hFFFF_FFFF,
          1'b1, 1'b1, 32'sd16129},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'hFFFF_FF80,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_WEIGHT, 6'd0, 8'd0, 32'h0000_0080,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, 32'sd16384},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_BIAS, 6'd0, 8'd255, 32'h7FFF_FFFF,
          1'b0, 1'b0, 32'sd0},
        // accumulator wraps past the int32 maximum
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, -32'sd2147467265},
        '{1'b1, CFG_VECTOR_LENGTH, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, 32'sd2147483647},
        '{1'b1, CFG_SHIFT_AMOUNT, 9'd1, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        // rounding carries past the int32 maximum before the shift
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, 32'sd1073741824},
        '{1'b1, CFG_SHIFT_AMOUNT, 9'd31, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, 32'sd1},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_BIAS, 6'd0, 8'd0, 32'h8000_0000,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, -32'sd1},
        '{1'b1, CFG_SHIFT_AMOUNT, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b1, CFG_NARROW_OUTPUT, 9'd1, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, -32'sd128},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_BIAS, 6'd0, 8'd0, 32'h7FFF_FFFF,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, 32'sd127},
        '{1'b1, CFG_RELU_ENABLE, 9'd1, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_BIAS, 6'd0, 8'd0, 32'h8000_0000,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b1, 32'sd0},
        '{1'b1, CFG_ROW_COUNT, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        // no rows, so no result
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b1, 1'b0, 32'sd0},
        '{1'b1, CFG_ROW_COUNT, 9'd2, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b1, CFG_RELU_ENABLE, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b1, CFG_NARROW_OUTPUT, 9'd0, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b1, CFG_VECTOR_LENGTH, 9'd1, KIND_ACT, 6'd0, 8'd0, 32'h0,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_BIAS, 6'd1, 8'd0, 32'h0000_03E8,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_WEIGHT, 6'd1, 8'd0, 32'hFFFF_FF05,
          1'b0, 1'b0, 32'sd0},
        '{1'b0, CFG_VECTOR_LENGTH, 9'd0, KIND_COMPUTE, 6'd0, 8'd0, 32'h0000_0000,
          1'b0, 1'b0, 32'sd0}
    };

    int8_fc_layer_requant_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .row_index    (row_index),
        .column_index (column_index),
        .data_value   (data_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_row   (result_row),
        .last_flag    (last_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] neuron_value(int j);
        int     taps;
        int     acc;
        longint v;
        taps = (vec_len > MAX_INPUTS_DEF) ? MAX_INPUTS_DEF : int'(vec_len);
        acc = bias_mirror[j];
        for (int i = 0; i < taps; i++)
            acc += int'(act_mirror[i]) * int'(wgt_mirror[j][i]);
        v = acc;
        if (shift_amt != 0)
        begin
            v = v + (longint'(1) << (shift_amt - 1));
            v = v >>> shift_amt;
        end
        if (relu_on && v < 0)
            v = 0;
        if (narrow_on)
        begin
            if (v > SAT_HI)
                v = SAT_HI;
            if (v < SAT_LO)
                v = SAT_LO;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic void absorb_word(kind_t k, logic [ROW_W-1:0] r,
                                        logic [COL_W-1:0] c, logic [DATA_W-1:0] d);
        int      rows;
        neuron_t nv;
        case (k)
            KIND_ACT:    act_mirror[c] = d[ELEM_W-1:0];
            KIND_WEIGHT: wgt_mirror[r][c] = d[ELEM_W-1:0];
            KIND_BIAS:   bias_mirror[r] = d;
            default:
            begin
                rows = (row_cnt > MAX_OUTPUTS_DEF) ? MAX_OUTPUTS_DEF : int'(row_cnt);
                for (int j = 0; j < rows; j++)
                begin
                    nv.value = neuron_value(j);
                    nv.row   = ROW_W'(j);
                    nv.last  = (j == rows - 1);
                    pending_neurons.push_back(nv);
                end
            end
        endcase
    endfunction

    task automatic send_word(kind_t k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                             logic [DATA_W-1:0] d);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        row_index    <= r;
        column_index <= c;
        data_value   <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic feed_word(kind_t k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                             logic [DATA_W-1:0] d);
        send_word(k, r, c, d);
        absorb_word(k, r, c, d);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_neurons.size() != 0)
            @(posedge clk);
        // queued load words leave no result behind
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VECTOR_LENGTH: vec_len   = val[VLEN_W-1:0];
            CFG_ROW_COUNT:     row_cnt   = val[RCNT_W-1:0];
            CFG_SHIFT_AMOUNT:  shift_amt = val[SHIFT_W-1:0];
            CFG_RELU_ENABLE:   relu_on   = val[0];
            CFG_NARROW_OUTPUT: narrow_on = val[0];
            default: ;
        endcase
    endtask

    // result side
    initial
    begin
        neuron_t want;
        int      gap_left;
        int      hold_left;
        bit      held;
        gap_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_neurons.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result: value %0d row %0d last %0b",
                                 result_value, result_row, last_flag);
                end
                else
                begin
                    want = pending_neurons.pop_front();
                    if (result_value !== want.value || result_row !== want.row ||
                        last_flag !== want.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch: expected value %0d row %0d last %0b,",
                                      " got value %0d row %0d last %0b"},
                                     want.value, want.row, want.last,
                                     result_value, result_row, last_flag);
                    end
                end
            end
            if (hold_left > 0)
                hold_left--;
            else if (squeeze && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            else if (gap_left > 0)
                gap_left--;
            else if (!calm && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 13);
            out_ready <= (hold_left == 0 && gap_left == 0);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("int8_fc_layer_requant_core_tb: FAIL");
        $finish;
    end

    initial
    begin
        neuron_t           typed_out;
        kind_t             k;
        int                vl;
        int                rc;
        int                sh;
        int                rl;
        int                nw;
        int                words;
        logic [DATA_W-1:0] d;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (direct_plan[s])
        begin
            if (direct_plan[s].is_reg)
                set_reg(direct_plan[s].reg_idx, direct_plan[s].reg_val);
            else
            begin
                send_word(direct_plan[s].kind, direct_plan[s].row, direct_plan[s].col,
                          direct_plan[s].data);
                if (!direct_plan[s].typed)
                    absorb_word(direct_plan[s].kind, direct_plan[s].row,
                                direct_plan[s].col, direct_plan[s].data);
                else if (direct_plan[s].has_out)
                begin
                    typed_out.value = direct_plan[s].out_val;
                    typed_out.row   = '0;
                    typed_out.last  = 1'b1;
                    pending_neurons.push_back(typed_out);
                end
            end
        end

        // fill the entries that the later settings read
        for (int c = 0; c < FILL_COLS; c++)
            feed_word(KIND_ACT, '0, COL_W'(c), $urandom);
        for (int r = 0; r < MAX_OUTPUTS_DEF; r++)
        begin
            feed_word(KIND_BIAS, ROW_W'(r), '0, $urandom);
            if (r < FILL_ROWS)
            begin
                for (int c = 0; c < FILL_COLS; c++)
                    feed_word(KIND_WEIGHT, ROW_W'(r), COL_W'(c), $urandom);
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            vl    = $urandom_range(1, FILL_COLS);
            rc    = $urandom_range(1, FILL_ROWS);
            sh    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
            rl    = $urandom_range(0, 1);
            nw    = $urandom_range(0, 1);
            words = 20;
            case (p)
                0:
                begin
                    vl = 0; rc = 127; sh = 0; rl = 0; nw = 0;
                    words = 4;
                end
                1:
                begin
                    vl = FILL_COLS; rc = FILL_ROWS; sh = 31; rl = 1; nw = 1;
                    words = 6;
                end
                2:
                begin
                    vl = 0; rc = 0;
                    words = 10;
                end
                3:
                begin
                    vl = 0;
                    words = 10;
                end
                default: ;
            endcase
            set_reg(CFG_VECTOR_LENGTH, CFG_DATA_W'(vl));
            set_reg(CFG_ROW_COUNT, CFG_DATA_W'(rc));
            set_reg(CFG_SHIFT_AMOUNT, CFG_DATA_W'(sh));
            set_reg(CFG_RELU_ENABLE, CFG_DATA_W'(rl));
            set_reg(CFG_NARROW_OUTPUT, CFG_DATA_W'(nw));
            squeeze = (p == 5);
            calm    = (p >= N_PHASES - 2);
            for (int n = 0; n < words; n++)
            begin
                if (n == words - 1 || $urandom_range(0, 4) == 0)
                    k = KIND_COMPUTE;
                else
                    k = kind_t'($urandom_range(0, 2));
                d = ($urandom_range(0, 7) == 0) ? DATA_CORNERS[$urandom_range(0, 5)]
                                                : $urandom;
                feed_word(k, ROW_W'($urandom), COL_W'($urandom), d);
            end
        end

        in_valid <= 1'b0;
        while (pending_neurons.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("int8_fc_layer_requant_core_tb: PASS");
        else
            $display("int8_fc_layer_requant_core_tb: FAIL");
        $finish;
    end

endmodule
